>>> rtl/diamond_square_heightmap_core_defines.svh
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core_defines
// Assertion macros used by the cell pipeline of the height grid generator RTL.
// ----------------------------------------------------------------------------
`ifndef DIAMOND_SQUARE_HEIGHTMAP_CORE_DEFINES_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DSH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared constants and types of the diamond-square height grid generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dsh_pkg;

  localparam int ORDER_W     = 3;
  localparam int SCALE_W     = 17;
  localparam int RAND_W      = 15;
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_OUT_W = 8;

  // Register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUGHNESS  = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
  localparam logic [SCALE_W-1:0] RATIO_RESET = 17'd41767;

  // Largest random word, 0x7fff, and half the 65534 divisor of the random term
  localparam int RAND_HALF = 32767;
  // Rounding offset of the Q1.16 scale product
  localparam int SCALE_ROUND = 32768;

  typedef struct packed {
    logic diamond;  // cell belongs to the diamond pass
    logic done;     // cell closes the whole generation
  } dsh_item_flags_t;

  typedef enum logic [1:0] {
    WR_IDLE,
    WR_MAIN,
    WR_MIRROR
  } dsh_wr_state_t;

endpackage

`default_nettype wire

>>> rtl/dsh_scan.sv
// ----------------------------------------------------------------------------
// dsh_scan
// Scan sequencer: stride, row, column, pass and level scale of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_scan #(
  parameter int MAX_ORDER = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dsh_pkg::ORDER_W-1:0]    grid_order,
  input  logic [dsh_pkg::SCALE_W-1:0]    roughness_ratio,
  input  logic                           start,
  input  logic                           step,
  output logic                           item_fire,
  output logic [MAX_ORDER:0]             item_row,
  output logic [MAX_ORDER:0]             item_col,
  output logic [MAX_ORDER:0]             item_stride,
  output logic [MAX_ORDER:0]             item_last,
  output logic [dsh_pkg::SCALE_W-1:0]    item_scale,
  output dsh_pkg::dsh_item_flags_t       item_flags
);
  import dsh_pkg::*;

  localparam int CW     = MAX_ORDER + 1;
  localparam int PROD_W = 2 * SCALE_W;

  logic [CW-1:0]      stride, stride_next;
  logic [CW-1:0]      crow, crow_next;
  logic [CW-1:0]      ccol, ccol_next;
  logic [CW-1:0]      run_last, run_last_next;
  logic               diamond, diamond_next;
  logic               odd_line, odd_line_next;
  logic               running, running_next;
  logic [SCALE_W-1:0] scale, scale_next;

  logic [CW-1:0]      last_start;
  logic [CW:0]        col_adv, row_adv2, row_adv1, last_ext;
  logic [PROD_W-1:0]  scale_prod;
  logic [PROD_W-17:0] scale_rnd;
  logic [SCALE_W-1:0] scale_sat;
  logic               done_c;

  // Clamp the order to 1..MAX_ORDER and form side-1
  always_comb begin
    if (grid_order == '0) begin
      last_start = CW'(2);
    end else if (32'(grid_order) > MAX_ORDER) begin
      last_start = CW'(1) << MAX_ORDER;
    end else begin
      last_start = CW'(1) << grid_order;
    end
  end

  // Next level scale, rounded Q1.16 product saturated to 17 bits
  always_comb begin
    scale_prod = PROD_W'(scale) * PROD_W'(roughness_ratio) + PROD_W'(SCALE_ROUND);
    scale_rnd  = scale_prod[PROD_W-1:16];
    scale_sat  = (scale_rnd > (PROD_W-16)'({SCALE_W{1'b1}})) ? {SCALE_W{1'b1}}
                                                              : scale_rnd[SCALE_W-1:0];
  end

  assign col_adv   = {1'b0, ccol} + {stride, 1'b0};
  assign row_adv2  = {1'b0, crow} + {stride, 1'b0};
  assign row_adv1  = {1'b0, crow} + {1'b0, stride};
  assign last_ext  = {1'b0, run_last};
  assign item_fire = step && running && (stride != '0);

  // Scan advance
  always_comb begin
    stride_next   = stride;
    crow_next     = crow;
    ccol_next     = ccol;
    run_last_next = run_last;
    diamond_next  = diamond;
    odd_line_next = odd_line;
    running_next  = running;
    scale_next    = scale;
    done_c        = 1'b0;
    if (start) begin
      run_last_next = last_start;
      stride_next   = last_start >> 1;
      crow_next     = last_start >> 1;
      ccol_next     = last_start >> 1;
      diamond_next  = 1'b0;
      odd_line_next = 1'b0;
      running_next  = 1'b1;
      scale_next    = roughness_ratio;
    end else if (item_fire) begin
      if (!diamond) begin
        if (col_adv >= last_ext) begin
          ccol_next = stride;
          if (row_adv2 >= last_ext) begin
            diamond_next  = 1'b1;
            crow_next     = '0;
            odd_line_next = 1'b1;
          end else begin
            crow_next = row_adv2[CW-1:0];
          end
        end else begin
          ccol_next = col_adv[CW-1:0];
        end
      end else begin
        if (col_adv >= last_ext) begin
          if (row_adv1 >= last_ext) begin
            // level finished
            scale_next    = scale_sat;
            stride_next   = stride >> 1;
            diamond_next  = 1'b0;
            odd_line_next = 1'b0;
            if ((stride >> 1) == '0) begin
              done_c       = 1'b1;
              running_next = 1'b0;
              crow_next    = '0;
              ccol_next    = '0;
            end else begin
              crow_next = stride >> 1;
              ccol_next = stride >> 1;
            end
          end else begin
            crow_next     = row_adv1[CW-1:0];
            odd_line_next = !odd_line;
            ccol_next     = !odd_line ? stride : '0;
          end
        end else begin
          ccol_next = col_adv[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stride   <= '0;
      crow     <= '0;
      ccol     <= '0;
      run_last <= CW'(2);
      diamond  <= 1'b0;
      odd_line <= 1'b0;
      running  <= 1'b0;
      scale    <= '0;
    end else begin
      stride   <= stride_next;
      crow     <= crow_next;
      ccol     <= ccol_next;
      run_last <= run_last_next;
      diamond  <= diamond_next;
      odd_line <= odd_line_next;
      running  <= running_next;
      scale    <= scale_next;
    end
  end

  assign item_row         = crow;
  assign item_col         = ccol;
  assign item_stride      = stride;
  assign item_last        = run_last;
  assign item_scale       = scale;
  assign item_flags.diamond = diamond;
  assign item_flags.done    = done_c;

endmodule

`default_nettype wire

>>> rtl/dsh_cell_pipe.sv
// ----------------------------------------------------------------------------
// dsh_cell_pipe
// Grid memory, neighbor reads with forwarding, height compute, write-back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "diamond_square_heightmap_core_defines.svh"

module dsh_cell_pipe #(
  parameter int MAX_ORDER    = 7,
  parameter int HEIGHT_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_fire,
  input  logic [MAX_ORDER:0]                  item_row,
  input  logic [MAX_ORDER:0]                  item_col,
  input  logic [MAX_ORDER:0]                  item_stride,
  input  logic [MAX_ORDER:0]                  item_last,
  input  logic [dsh_pkg::SCALE_W-1:0]         item_scale,
  input  logic [dsh_pkg::RAND_W-1:0]          item_rand,
  input  dsh_pkg::dsh_item_flags_t            item_flags,
  output logic                                item_ready,
  input  logic                                q_space,
  output logic                                q_push,
  output logic [dsh_pkg::COORD_OUT_W-1:0]     q_row0,
  output logic [dsh_pkg::COORD_OUT_W-1:0]     q_col0,
  output logic [dsh_pkg::COORD_OUT_W-1:0]     q_row1,
  output logic [dsh_pkg::COORD_OUT_W-1:0]     q_col1,
  output logic signed [HEIGHT_WIDTH-1:0]      q_height,
  output logic                                q_two,
  output logic                                q_done
);
  import dsh_pkg::*;

  localparam int CW     = MAX_ORDER + 1;
  localparam int SIDE   = (1 << MAX_ORDER) + 1;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SUM_W  = HEIGHT_WIDTH + 2;
  localparam int T_W    = RAND_W + 2;
  localparam int PROD_W = SCALE_W + 1 + T_W;
  localparam int Y_W    = PROD_W - 1;
  localparam int A_W    = Y_W - 15;
  localparam int Q_W    = A_W + 1;
  localparam int EW     = ((SUM_W > Q_W) ? SUM_W : Q_W) + 1;
  localparam logic [2:0] CNT_DONE = 3'd4;
  localparam logic signed [EW-1:0] H_MAX = EW'((64'sd1 <<< (HEIGHT_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] H_MIN = -H_MAX - EW'(1);

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return (AW'(r) << MAX_ORDER) + AW'(r) + AW'(c);
  endfunction

  // Read stage
  logic                    rs_valid;
  logic [2:0]              rs_cnt;
  logic [CW-1:0]           ri, rj, rstr, rlast;
  dsh_item_flags_t         rflags;
  logic [SCALE_W-1:0]      rscale;
  logic [RAND_W-1:0]       rrand;
  logic signed [PROD_W-1:0] n_q;
  logic signed [Q_W-1:0]   q_q;
  logic signed [SUM_W-1:0] sum;
  logic                    rs_go;

  // Memory and forwarding
  logic signed [HEIGHT_WIDTH-1:0] mem [DEPTH];
  logic signed [HEIGHT_WIDTH-1:0] rd_data;
  logic                    rd_en, rd_pend, rd_zero_q, corner;
  logic [AW-1:0]           rd_addr, rd_addr_q;
  logic [CW-1:0]           nr, nc, up, left;
  logic signed [HEIGHT_WIDTH-1:0] fwd, data_in;
  logic signed [SUM_W-1:0] sum_full, avg;

  // Random term
  logic signed [T_W-1:0]   t_val;
  logic [PROD_W-1:0]       mag;
  logic [Y_W-1:0]          y_val;
  logic [A_W-1:0]          a_val;
  logic [A_W:0]            u_val;
  logic [15:0]             v_val;
  logic [A_W-1:0]          qm;
  logic signed [Q_W-1:0]   q_next;

  // Height and write-back
  logic signed [EW-1:0]    hsum;
  logic signed [HEIGHT_WIDTH-1:0] h_sat;
  logic                    mrow, mcol;
  logic                    wb_valid, wb_two;
  logic [AW-1:0]           wb_a0, wb_a1;
  logic signed [HEIGHT_WIDTH-1:0] wb_h;
  dsh_wr_state_t           wr_state, wr_state_next;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  assign rs_go      = rs_valid && (rs_cnt == CNT_DONE) && q_space;
  assign item_ready = !rs_valid || rs_go;
  assign rd_en      = rs_valid && (rs_cnt != CNT_DONE);
  assign mrow       = rflags.diamond && (ri == '0);
  assign mcol       = rflags.diamond && (rj == '0);

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid <= 1'b0;
      rs_cnt   <= '0;
    end else if (item_fire) begin
      rs_valid <= 1'b1;
      rs_cnt   <= '0;
    end else if (rs_go) begin
      rs_valid <= 1'b0;
    end else if (rd_en) begin
      rs_cnt <= rs_cnt + 3'd1;
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    if (item_fire) begin
      ri     <= item_row;
      rj     <= item_col;
      rstr   <= item_stride;
      rlast  <= item_last;
      rflags <= item_flags;
      rscale <= item_scale;
      rrand  <= item_rand;
    end
    sum <= item_fire ? '0 : sum_full;
    n_q <= $signed({1'b0, rscale}) * t_val;
    q_q <= q_next;
  end

  // Random term: round(scale*(2r-32767)/65534), ties away from zero
  assign t_val = $signed({1'b0, rrand, 1'b0}) - T_W'(RAND_HALF);

  always_comb begin
    mag    = (n_q[PROD_W-1] ? PROD_W'(-n_q) : PROD_W'(n_q)) + PROD_W'(RAND_HALF);
    y_val  = mag[PROD_W-1:1];
    a_val  = y_val[Y_W-1:15];
    u_val  = (A_W+1)'(a_val) + (A_W+1)'(y_val[14:0]);
    v_val  = 16'(u_val[A_W:15]) + 16'(u_val[14:0]);
    qm     = a_val + A_W'(u_val[A_W:15]) + A_W'(v_val >= 16'(RAND_HALF));
    q_next = n_q[PROD_W-1] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  // Neighbor select, diamond neighbors wrap at row and column zero
  always_comb begin
    up   = (ri == '0) ? rlast - rstr : ri - rstr;
    left = (rj == '0) ? rlast - rstr : rj - rstr;
    nr   = ri;
    nc   = rj;
    unique case (rs_cnt[1:0])
      2'd0: begin
        nr = rflags.diamond ? up : ri - rstr;
        nc = rflags.diamond ? rj : rj - rstr;
      end
      2'd1: begin
        nr = rflags.diamond ? ri + rstr : ri - rstr;
        nc = rflags.diamond ? rj : rj + rstr;
      end
      2'd2: begin
        nr = rflags.diamond ? ri : ri + rstr;
        nc = rflags.diamond ? left : rj - rstr;
      end
      2'd3: begin
        nr = ri + rstr;
        nc = rj + rstr;
        if (rflags.diamond) begin
          nr = ri;
        end
      end
    endcase
    corner  = ((nr == '0) || (nr == rlast)) && ((nc == '0) || (nc == rlast));
    rd_addr = cell_addr(nr, nc);
  end

  // Grid memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wb_h;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
    end
    rd_addr_q <= rd_addr;
    rd_zero_q <= corner;
  end

  // Corners read as zero; the previous cell's writes are forwarded
  always_comb begin
    if (rd_zero_q) begin
      fwd = '0;
    end else if (wb_valid && (rd_addr_q == wb_a0)) begin
      fwd = wb_h;
    end else if (wb_valid && wb_two && (rd_addr_q == wb_a1)) begin
      fwd = wb_h;
    end else begin
      fwd = rd_data;
    end
    data_in  = rd_pend ? fwd : '0;
    sum_full = sum + SUM_W'(data_in);
    avg      = sum_full >>> 2;
    hsum     = EW'(avg) + EW'(q_q);
    if (hsum > H_MAX) begin
      h_sat = HEIGHT_WIDTH'(H_MAX);
    end else if (hsum < H_MIN) begin
      h_sat = HEIGHT_WIDTH'(H_MIN);
    end else begin
      h_sat = HEIGHT_WIDTH'(hsum);
    end
  end

  // Write-back registers, held until the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (rs_go) begin
      wb_valid <= 1'b1;
    end
    if (rs_go) begin
      wb_a0  <= cell_addr(ri, rj);
      wb_a1  <= cell_addr(mrow ? rlast : ri, mcol ? rlast : rj);
      wb_two <= mrow || mcol;
      wb_h   <= h_sat;
    end
  end

  // Write sequencer: cell, then its mirror copy when there is one
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_state <= WR_IDLE;
    end else begin
      wr_state <= wr_state_next;
    end
  end

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = wb_a0;
    wr_state_next = wr_state;
    unique case (wr_state)
      WR_IDLE: begin
        wr_state_next = WR_IDLE;
      end
      WR_MAIN: begin
        wr_en         = 1'b1;
        wr_state_next = wb_two ? WR_MIRROR : WR_IDLE;
      end
      WR_MIRROR: begin
        wr_en         = 1'b1;
        wr_addr       = wb_a1;
        wr_state_next = WR_IDLE;
      end
      default: begin
        wr_state_next = WR_IDLE;
      end
    endcase
    if (rs_go) begin
      wr_state_next = WR_MAIN;
    end
  end

  // Result entry
  assign q_push   = rs_go;
  assign q_row0   = COORD_OUT_W'(ri);
  assign q_col0   = COORD_OUT_W'(rj);
  assign q_row1   = COORD_OUT_W'(mrow ? rlast : ri);
  assign q_col1   = COORD_OUT_W'(mcol ? rlast : rj);
  assign q_height = h_sat;
  assign q_two    = mrow || mcol;
  assign q_done   = rflags.done;

  `DSH_ASSERT_SAME(a_item_slot_free, clk, rst, item_fire, !rs_valid || rs_go, "item into busy read stage")
  `DSH_ASSERT_SAME(a_write_port_free, clk, rst, rs_go, wr_state == WR_IDLE, "write sequencer still busy")
  `DSH_ASSERT_NEXT(a_write_follows, clk, rst, rs_go, wr_state == WR_MAIN, "cell write not started")

endmodule

`default_nettype wire

>>> rtl/dsh_result_q.sv
// ----------------------------------------------------------------------------
// dsh_result_q
// Two-entry result queue; each entry drives one or two output requests.
// ----------------------------------------------------------------------------
`default_nettype none

module dsh_result_q #(
  parameter int HEIGHT_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]  push_row0,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]  push_col0,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]  push_row1,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]  push_col1,
  input  logic signed [HEIGHT_WIDTH-1:0]   push_height,
  input  logic                             push_two,
  input  logic                             push_done,
  output logic                             space,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dsh_pkg::COORD_OUT_W-1:0]  row,
  output logic [dsh_pkg::COORD_OUT_W-1:0]  col,
  output logic signed [HEIGHT_WIDTH-1:0]   height,
  output logic                             last_of_run,
  output logic                             grid_done
);
  import dsh_pkg::*;

  logic [COORD_OUT_W-1:0] e_row0 [2];
  logic [COORD_OUT_W-1:0] e_col0 [2];
  logic [COORD_OUT_W-1:0] e_row1 [2];
  logic [COORD_OUT_W-1:0] e_col1 [2];
  logic signed [HEIGHT_WIDTH-1:0] e_h [2];
  logic [1:0] e_two, e_done;
  logic       wr_ptr, rd_ptr, beat, pop;
  logic [1:0] count;

  assign space       = (count != 2'd2);
  assign out_valid   = (count != 2'd0);
  assign last_of_run = beat || !e_two[rd_ptr];
  assign grid_done   = e_done[rd_ptr] && last_of_run;
  assign row         = beat ? e_row1[rd_ptr] : e_row0[rd_ptr];
  assign col         = beat ? e_col1[rd_ptr] : e_col0[rd_ptr];
  assign height      = e_h[rd_ptr];
  assign pop         = out_valid && out_ready && last_of_run;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      e_row0[wr_ptr] <= push_row0;
      e_col0[wr_ptr] <= push_col0;
      e_row1[wr_ptr] <= push_row1;
      e_col1[wr_ptr] <= push_col1;
      e_h[wr_ptr]    <= push_height;
      e_two[wr_ptr]  <= push_two;
      e_done[wr_ptr] <= push_done;
    end
  end

  // Pointers, fill count and beat within an entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      beat   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        beat   <= 1'b0;
      end else if (out_valid && out_ready) begin
        beat <= 1'b1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/diamond_square_heightmap_core.sv
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core
// Tileable diamond-square height grid generator, one cell per random word.
// ----------------------------------------------------------------------------
// Usage: write grid_order and roughness_ratio on the config port while idle,
// then send a request with mode 0 to start a grid (no result). Each mode 1
// request carries one random word and yields the next cell on the output
// channel: one result, or two when the cell lies on row 0 or column 0 of
// the diamond pass (the second is its wrapped mirror copy). last_of_run
// marks the final result of a request, grid_done the last of the grid.
// Words sent while no grid is running are taken and give nothing.
// Throughput: a word is taken only once the previous cell has made its four
// neighbor reads on the single read port of the grid memory and its result
// has entered the result queue; the output is driven from that queue.
// A stalled receiver fills a two-entry result queue, after which input
// ready drops; nothing is lost. Reset clears control state only; the grid
// memory needs no clearing pass and the block waits for a start request.
// ----------------------------------------------------------------------------
`default_nettype none

module diamond_square_heightmap_core #(
  parameter int MAX_ORDER    = 7,
  parameter int HEIGHT_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dsh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dsh_pkg::SCALE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [dsh_pkg::RAND_W-1:0]         rand_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dsh_pkg::COORD_OUT_W-1:0]    row,
  output logic [dsh_pkg::COORD_OUT_W-1:0]    col,
  output logic signed [HEIGHT_WIDTH-1:0]     height,
  output logic                               last_of_run,
  output logic                               grid_done
);
  import dsh_pkg::*;

  logic [ORDER_W-1:0] grid_order;
  logic [SCALE_W-1:0] roughness_ratio;
  logic               in_fire, start, step, item_fire, q_space, q_push;
  logic [MAX_ORDER:0] item_row, item_col, item_stride, item_last;
  logic [SCALE_W-1:0] item_scale;
  dsh_item_flags_t    item_flags;
  logic [COORD_OUT_W-1:0] q_row0, q_col0, q_row1, q_col1;
  logic signed [HEIGHT_WIDTH-1:0] q_height;
  logic               q_two, q_done;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order      <= ORDER_RESET;
      roughness_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_ORDER: grid_order      <= cfg_data[ORDER_W-1:0];
        CFG_ROUGHNESS:  roughness_ratio <= cfg_data;
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;
  assign start   = in_fire && !mode;
  assign step    = in_fire && mode;

  dsh_scan #(
    .MAX_ORDER(MAX_ORDER)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .grid_order     (grid_order),
    .roughness_ratio(roughness_ratio),
    .start          (start),
    .step           (step),
    .item_fire      (item_fire),
    .item_row       (item_row),
    .item_col       (item_col),
    .item_stride    (item_stride),
    .item_last      (item_last),
    .item_scale     (item_scale),
    .item_flags     (item_flags)
  );

  dsh_cell_pipe #(
    .MAX_ORDER   (MAX_ORDER),
    .HEIGHT_WIDTH(HEIGHT_WIDTH)
  ) u_cell_pipe (
    .clk        (clk),
    .rst        (rst),
    .item_fire  (item_fire),
    .item_row   (item_row),
    .item_col   (item_col),
    .item_stride(item_stride),
    .item_last  (item_last),
    .item_scale (item_scale),
    .item_rand  (rand_word),
    .item_flags (item_flags),
    .item_ready (in_ready),
    .q_space    (q_space),
    .q_push     (q_push),
    .q_row0     (q_row0),
    .q_col0     (q_col0),
    .q_row1     (q_row1),
    .q_col1     (q_col1),
    .q_height   (q_height),
    .q_two      (q_two),
    .q_done     (q_done)
  );

  dsh_result_q #(
    .HEIGHT_WIDTH(HEIGHT_WIDTH)
  ) u_result_q (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_row0  (q_row0),
    .push_col0  (q_col0),
    .push_row1  (q_row1),
    .push_col1  (q_col1),
    .push_height(q_height),
    .push_two   (q_two),
    .push_done  (q_done),
    .space      (q_space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row        (row),
    .col        (col),
    .height     (height),
    .last_of_run(last_of_run),
    .grid_done  (grid_done)
  );

endmodule

`default_nettype wire

>>> test/diamond_square_heightmap_core_checker.sv
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core_checker
// Watches both channels of the height grid generator, predicts each cell
// from its own copy of the grid, scan position and scale, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module diamond_square_heightmap_core_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dsh_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dsh_pkg::SCALE_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  mode,
  input  logic [dsh_pkg::RAND_W-1:0]            rand_word,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]       row,
  input  logic [dsh_pkg::COORD_OUT_W-1:0]       col,
  input  logic signed [23:0]                    height,
  input  logic                                  last_of_run,
  input  logic                                  grid_done,
  output int                                    fail_count,
  output int                                    pending_cells
);
  import dsh_pkg::*;

  localparam int MAXO = 7;
  localparam int SIDE_MAX = (1 << MAXO) + 1;
  localparam longint HMAX = (64'sd1 <<< 23) - 1;
  localparam longint HMIN = -(64'sd1 <<< 23);

  typedef struct packed {
    logic [7:0]         r;
    logic [7:0]         c;
    logic signed [23:0] h;
    logic               last;
    logic               done;
  } cell_t;

  cell_t cell_q[$];
  longint grid[SIDE_MAX*SIDE_MAX];
  int unsigned order_reg, ratio_reg, run_order;
  int unsigned stride, cr, cc, scale;
  bit diamond, odd, running;

  assign pending_cells = cell_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (row %0d col %0d)", what, got, want, row, col);
    fail_count++;
  endtask

  function automatic longint gget(int unsigned r, int unsigned c, int unsigned side);
    if (r >= side || c >= side) return 0;
    return grid[r*side + c];
  endfunction

  task automatic gput(int unsigned r, int unsigned c, int unsigned side, longint v);
    if (r < side && c < side) grid[r*side + c] = v;
  endtask

  // Compute cells caused by one request
  task automatic predict_cells(input bit m, input int unsigned rw);
    int unsigned side, lst, s, i, j, up, lf;
    longint sum, avg, n, q, h, ns;
    bit done, mr, mc;
    cell_t e;
    done = 0;
    if (!m) begin
      run_order = order_reg < 1 ? 1 : (order_reg > MAXO ? MAXO : order_reg);
      side = (1 << run_order) + 1;
      lst = side - 1;
      gput(0, 0, side, 0); gput(0, lst, side, 0);
      gput(lst, 0, side, 0); gput(lst, lst, side, 0);
      scale = ratio_reg;
      stride = lst / 2;
      cr = stride; cc = stride;
      diamond = 0; odd = 0; running = 1;
      return;
    end
    if (!running || stride == 0) return;
    side = (1 << run_order) + 1;
    lst = side - 1;
    s = stride; i = cr; j = cc;
    if (!diamond) begin
      sum = gget(i-s, j-s, side) + gget(i-s, j+s, side)
          + gget(i+s, j-s, side) + gget(i+s, j+s, side);
    end else begin
      up = (i == 0) ? lst - s : i - s;
      lf = (j == 0) ? lst - s : j - s;
      sum = gget(up, j, side) + gget(i+s, j, side) + gget(i, lf, side) + gget(i, j+s, side);
    end
    avg = sum >= 0 ? sum / 4 : -((-sum + 3) / 4);
    n = longint'(scale) * (2*longint'(rw) - RAND_HALF);
    q = n >= 0 ? (n + 32767) / 65534 : -((-n + 32767) / 65534);
    h = avg + q;
    h = h > HMAX ? HMAX : (h < HMIN ? HMIN : h);
    gput(i, j, side, h);
    mr = diamond && i == 0;
    mc = diamond && j == 0;
    if (mr) gput(lst, j, side, h);
    if (mc) gput(i, lst, side, h);
    // advance the scan
    if (!diamond) begin
      cc = j + 2*s;
      if (cc >= lst) begin
        cc = s; cr = i + 2*s;
        if (cr >= lst) begin
          diamond = 1; cr = 0; odd = 1; cc = s;
        end
      end
    end else begin
      cc = j + 2*s;
      if (cc >= lst) begin
        cr = i + s;
        if (cr >= lst) begin
          ns = (longint'(scale) * ratio_reg + SCALE_ROUND) >>> 16;
          scale = ns > 'h1FFFF ? 'h1FFFF : int'(ns);
          stride = s >> 1;
          diamond = 0; odd = 0;
          if (stride == 0) begin
            done = 1; running = 0; cr = 0; cc = 0;
          end else begin
            cr = stride; cc = stride;
          end
        end else begin
          odd = !odd;
          cc = odd ? s : 0;
        end
      end
    end
    e.h = h[23:0];
    if (mr || mc) begin
      e.r = 8'(i); e.c = 8'(j); e.last = 0; e.done = 0;
      cell_q.push_back(e);
      e.r = 8'(mr ? lst : i); e.c = 8'(mc ? lst : j); e.last = 1; e.done = done;
      cell_q.push_back(e);
    end else begin
      e.r = 8'(i); e.c = 8'(j); e.last = 1; e.done = done;
      cell_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    cell_t e;
    if (rst) begin
      fail_count = 0;
      cell_q.delete();
      order_reg = 32'(ORDER_RESET); ratio_reg = 32'(RATIO_RESET); run_order = 1;
      stride = 0; cr = 0; cc = 0; scale = 0;
      diamond = 0; odd = 0; running = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_ORDER) order_reg = 32'(cfg_data[ORDER_W-1:0]);
        else if (cfg_index == CFG_ROUGHNESS) ratio_reg = 32'(cfg_data);
      end
      if (in_valid && in_ready) predict_cells(mode, 32'(rand_word));
      // compare each accepted cell with the oldest prediction
      if (out_valid && out_ready) begin
        if (cell_q.size() == 0) begin
          report("unexpected cell", 1, 0);
        end else begin
          e = cell_q.pop_front();
          if (row !== e.r) report("row", row, e.r);
          if (col !== e.c) report("col", col, e.c);
          if (height !== e.h) report("height", height, e.h);
          if (last_of_run !== e.last) report("last_of_run", last_of_run, e.last);
          if (grid_done !== e.done) report("grid_done", grid_done, e.done);
        end
      end
    end
  end
endmodule

`default_nettype wire

>>> test/diamond_square_heightmap_core_tb.sv
// ----------------------------------------------------------------------------
// diamond_square_heightmap_core_tb
// Drives start and random-word requests through several grid orders and
// roughness settings with random gaps and stalls; the checker compares.
// ----------------------------------------------------------------------------
`default_nettype none

module diamond_square_heightmap_core_tb;
  import dsh_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_ORDER;
  logic [SCALE_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready, mode = 0;
  logic [RAND_W-1:0] rand_word = '0;
  logic out_valid, out_ready = 0;
  logic [COORD_OUT_W-1:0] row, col;
  logic signed [23:0] height;
  logic last_of_run, grid_done;
  int fail_count, pending_cells, cycles = 0, words_sent = 0;
  bit hold_rx = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  diamond_square_heightmap_core dut (.*);
  diamond_square_heightmap_core_checker chk (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, one long hold-off, always ready after 600 words
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold_rx) out_ready <= 0;
    else if (words_sent > 600) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  initial begin
    @(posedge clk);
    wait (words_sent > 200);
    hold_rx = 1;
    repeat (200) @(posedge clk);
    hold_rx = 0;
  end

  // valid stays high across back-to-back requests; gaps and drain drop it
  task automatic send(input bit m, input int unsigned rw);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1; mode <= m; rand_word <= rw[RAND_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m) words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v[SCALE_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    repeat (8) @(posedge clk);
    while (pending_cells != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one grid: start plus enough words to finish (and a few extra)
  task automatic run_grid(input int ord, input int extra, input int kind);
    int side, cells, o;
    o = (ord < 1) ? 1 : ord;
    side = (1 << o) + 1;
    cells = (side - 1)*(side - 1) - 1;
    send(0, 0);
    repeat (cells + extra) begin
      case (kind)
        0: send(1, $urandom_range(0, 32767));
        1: send(1, 32767);
        default: send(1, 0);
      endcase
    end
  endtask

  initial begin
    int n, ord;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: idle words, order 1 default, extremes
    send(1, 32767);
    send(1, 0);
    run_grid(1, 2, 1);
    drain();
    write_reg(CFG_GRID_ORDER, 0);
    write_reg(CFG_ROUGHNESS, 65536);
    run_grid(0, 1, 2);
    drain();
    write_reg(CFG_ROUGHNESS, 0);
    write_reg(CFG_GRID_ORDER, 2);
    run_grid(2, 0, 1);
    drain();
    // restart mid-run, and max ratio with all-high words to saturate
    write_reg(CFG_ROUGHNESS, 131071);
    write_reg(CFG_GRID_ORDER, 3);
    send(0, 0);
    send(1, 12345);
    send(1, 21845);
    run_grid(3, 0, 1);
    drain();
    // random part
    n = 0;
    while (words_sent < 1400) begin
      write_reg(CFG_ROUGHNESS, n % 5 == 0 ? 65536 : $urandom_range(0, 131071));
      ord = (n == 3) ? 7 : $urandom_range(0, 4);
      write_reg(CFG_GRID_ORDER, ord);
      if ($urandom_range(0, 9) == 0) begin
        send(0, 0);
        repeat ($urandom_range(1, 8)) send(1, $urandom_range(0, 32767));
      end
      if (n == 3) begin
        // partial run at the largest order
        send(0, 0);
        repeat (150) send(1, $urandom_range(0, 32767));
      end else begin
        run_grid(ord, $urandom_range(0, 2), $urandom_range(0, 15) == 0);
      end
      drain();
      n++;
    end
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/dsh_pkg.sv
rtl/dsh_scan.sv
rtl/dsh_cell_pipe.sv
rtl/dsh_result_q.sv
rtl/diamond_square_heightmap_core.sv
test/diamond_square_heightmap_core_checker.sv
test/diamond_square_heightmap_core_tb.sv
